// File: design/rrs_pkg.sv
// shared types and constants of the raster resampler
package rrs_pkg;

    localparam int FRAC_W     = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COORD_W    = 28;
    localparam int SAMPLE_W   = 33;
    localparam int OUT_W      = 49;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 12;
    localparam int DIM_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int WEIGHT_W   = FRAC_W + 1;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // request kinds
    typedef enum logic [1:0] {
        K_FRAME = 2'd0,
        K_ROW   = 2'd1,
        K_LOAD  = 2'd2,
        K_CELL  = 2'd3
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_START_X = 3'd1,
        REG_START_Y = 3'd2,
        REG_STEP_X  = 3'd3,
        REG_STEP_Y  = 3'd4,
        REG_NODATA  = 3'd5,
        REG_WIDTH   = 3'd6,
        REG_HEIGHT  = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic                mode;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  step_x;
        logic [COORD_W-1:0]  step_y;
        logic [SAMPLE_W-1:0] nodata;
        logic [12:0]         raster_width;
        logic [15:0]         raster_height;
    } t_cfg;

    // classified request passed from front to back
    typedef struct packed {
        t_kind               kind;
        logic                mode;
        logic                slot;
        logic [SAMPLE_W-1:0] sample;
        logic [ADDR_W-1:0]   xi;
        logic [WEIGHT_W-1:0] fx;
        logic [WEIGHT_W-1:0] fy;
        logic [ROW_W-1:0]    upper;
        logic [ROW_W-1:0]    lower;
    } t_cmd;

endpackage

// File: design/raster_resampler_nn_bilinear.sv
// top level of the raster resampler: configuration registers, front, queue and back
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  request  | push / full        | kind, row_index, column_index, line_slot, sample
//  result   | empty / pop        | cell_value, cell_valid, running_min/max, rows
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// the front takes one request at a time through its product, saturate and index stages.
// the back handles frame, row and load requests without a line store read; a nearest cell
// reads the line stores once, a bilinear cell reads them twice and then takes eight steps
// of the one shared multiplier. a two-entry queue sits between front and back.
// synchronous active-low reset clears control and trackers; line stores are not
// cleared. a result waits in the output register while the front keeps going.
module raster_resampler_nn_bilinear import rrs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_kind,
    input  logic [ROW_W-1:0]           i_row_index,
    input  logic [COL_W-1:0]           i_column_index,
    input  logic                       i_line_slot,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [OUT_W-1:0]    o_cell_value,
    output logic                       o_cell_valid,
    output logic signed [OUT_W-1:0]    o_running_min,
    output logic signed [OUT_W-1:0]    o_running_max,
    output logic [ROW_W-1:0]           o_upper_source_row,
    output logic [ROW_W-1:0]           o_lower_source_row,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [SAMPLE_W-1:0]        i_cfg_data
);

    t_cfg r_cfg;
    logic front_busy;
    logic cmd_push;
    t_cmd cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= 1'b1;
            r_cfg.start_x       <= '0;
            r_cfg.start_y       <= '0;
            r_cfg.step_x        <= COORD_W'(65536);
            r_cfg.step_y        <= COORD_W'(65536);
            r_cfg.nodata        <= '0;
            r_cfg.raster_width  <= 13'd4096;
            r_cfg.raster_height <= 16'd65535;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_MODE:    r_cfg.mode          <= i_cfg_data[0];
                REG_START_X: r_cfg.start_x       <= i_cfg_data[COORD_W-1:0];
                REG_START_Y: r_cfg.start_y       <= i_cfg_data[COORD_W-1:0];
                REG_STEP_X:  r_cfg.step_x        <= i_cfg_data[COORD_W-1:0];
                REG_STEP_Y:  r_cfg.step_y        <= i_cfg_data[COORD_W-1:0];
                REG_NODATA:  r_cfg.nodata        <= i_cfg_data;
                REG_WIDTH:   r_cfg.raster_width  <= i_cfg_data[12:0];
                REG_HEIGHT:  r_cfg.raster_height <= i_cfg_data[15:0];
                default:     r_cfg.mode          <= r_cfg.mode;
            endcase
        end
    end

    // request classification
    rrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_busy         (front_busy),
        .i_kind         (i_kind),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_line_slot    (i_line_slot),
        .i_sample       (i_sample),
        .i_q_full       (q_full),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd)
    );

    // request queue
    rrs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // execution
    rrs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .i_head             (q_head),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_cell_value       (o_cell_value),
        .o_cell_valid       (o_cell_valid),
        .o_running_min      (o_running_min),
        .o_running_max      (o_running_max),
        .o_upper_source_row (o_upper_source_row),
        .o_lower_source_row (o_lower_source_row)
    );

    assign full = front_busy;

endmodule

// File: design/rrs_ram.sv
// generic single-write, single-read ram with registered read
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rrs_cmdq.sv
// two-entry request queue between front and back
module rrs_cmdq import rrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

endmodule

// File: design/rrs_front.sv
// front end: takes requests, maps grid indexes to source coordinates and indexes
module rrs_front import rrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_push,
    output logic                o_busy,
    input  logic [1:0]          i_kind,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [COL_W-1:0]    i_column_index,
    input  logic                i_line_slot,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_q_full,
    output logic                o_cmd_push,
    output t_cmd                o_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_SAT, F_IDX} t_fstate;

    typedef struct packed {
        logic [DIM_W-1:0]    idx;
        logic [WEIGHT_W-1:0] frac;
    } t_bil;

    localparam logic [FRAC_W-1:0] HALF = {1'b1, {(FRAC_W-1){1'b0}}};

    t_fstate               r_state;
    t_kind                 r_kind;
    logic [COL_W-1:0]      r_col;
    logic                  r_slot;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [COL_W+COORD_W-1:0] r_px;
    logic [ROW_W+COORD_W-1:0] r_py;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;

    logic [COL_W+COORD_W:0] sum_x;
    logic [ROW_W+COORD_W:0] sum_y;
    logic [DIM_W-1:0]       dim_x;
    logic [DIM_W-1:0]       dim_y;
    logic [DIM_W-1:0]       nn_x;
    logic [DIM_W-1:0]       nn_y;
    t_bil                   bil_x;
    t_bil                   bil_y;

    // nearest index, rounding fractions above one half up
    function automatic logic [DIM_W-1:0] nn_index(input logic [COORD_W-1:0] c,
                                                  input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] i;
        i = {{(DIM_W-COORD_W+FRAC_W){1'b0}}, c[COORD_W-1:FRAC_W]}
            + {{(DIM_W-1){1'b0}}, (c[FRAC_W-1:0] > HALF)};
        if (i > dim - DIM_W'(1)) begin
            i = dim - DIM_W'(1);
        end
        return i;
    endfunction

    // upper/left neighbour and far weight, clamped at the last edge
    function automatic t_bil bil_base(input logic [COORD_W-1:0] c,
                                      input logic [DIM_W-1:0] dim);
        logic [DIM_W+FRAC_W-1:0] lim;
        logic [COORD_W-1:0]      cc;
        logic [DIM_W-1:0]        i;
        logic [DIM_W+FRAC_W-1:0] diff;
        t_bil                    r;
        lim = {{FRAC_W{1'b0}}, dim - DIM_W'(1)} << FRAC_W;
        cc = ({{(DIM_W+FRAC_W-COORD_W){1'b0}}, c} > lim) ? lim[COORD_W-1:0] : c;
        i = {{(DIM_W-COORD_W+FRAC_W){1'b0}}, cc[COORD_W-1:FRAC_W]};
        if (i > dim - DIM_W'(2)) begin
            i = dim - DIM_W'(2);
        end
        diff = {{(DIM_W+FRAC_W-COORD_W){1'b0}}, cc} - ({{FRAC_W{1'b0}}, i} << FRAC_W);
        r.idx  = i;
        r.frac = diff[WEIGHT_W-1:0];
        return r;
    endfunction

    // state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_state <= F_SAT;
                    end
                end
                F_SAT: begin
                    r_state <= F_IDX;
                end
                F_IDX: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // request capture, products and saturated coordinates
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_kind   <= t_kind'(i_kind);
            r_col    <= i_column_index;
            r_slot   <= i_line_slot;
            r_sample <= i_sample;
            r_px     <= {{COORD_W{1'b0}}, i_column_index} * {{COL_W{1'b0}}, i_cfg.step_x};
            r_py     <= {{COORD_W{1'b0}}, i_row_index} * {{ROW_W{1'b0}}, i_cfg.step_y};
        end
        if (r_state == F_SAT) begin
            r_x <= (|sum_x[COL_W+COORD_W:COORD_W]) ? {COORD_W{1'b1}} : sum_x[COORD_W-1:0];
            r_y <= (|sum_y[ROW_W+COORD_W:COORD_W]) ? {COORD_W{1'b1}} : sum_y[COORD_W-1:0];
        end
    end

    assign sum_x = {{(COL_W+1){1'b0}}, i_cfg.start_x} + {1'b0, r_px};
    assign sum_y = {{(ROW_W+1){1'b0}}, i_cfg.start_y} + {1'b0, r_py};

    // effective raster size
    always_comb begin
        dim_x = {4'd0, i_cfg.raster_width};
        if (dim_x < DIM_W'(2)) begin
            dim_x = DIM_W'(2);
        end else if (dim_x > DIM_W'(MAX_WIDTH)) begin
            dim_x = DIM_W'(MAX_WIDTH);
        end
        dim_y = {1'b0, i_cfg.raster_height};
        if (dim_y < DIM_W'(2)) begin
            dim_y = DIM_W'(2);
        end
    end

    assign nn_x  = nn_index(r_x, dim_x);
    assign nn_y  = nn_index(r_y, dim_y);
    assign bil_x = bil_base(r_x, dim_x);
    assign bil_y = bil_base(r_y, dim_y);

    // classified request
    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = r_kind;
        o_cmd.mode   = i_cfg.mode;
        o_cmd.slot   = r_slot;
        o_cmd.sample = r_sample;
        o_cmd.fx     = bil_x.frac;
        o_cmd.fy     = bil_y.frac;
        if (r_kind == K_LOAD) begin
            o_cmd.xi = r_col[ADDR_W-1:0];
        end else if (i_cfg.mode) begin
            o_cmd.xi = bil_x.idx[ADDR_W-1:0];
        end else begin
            o_cmd.xi = nn_x[ADDR_W-1:0];
        end
        if (r_kind == K_ROW) begin
            if (i_cfg.mode) begin
                o_cmd.upper = bil_y.idx[ROW_W-1:0];
                o_cmd.lower = bil_y.idx[ROW_W-1:0] + ROW_W'(1);
            end else begin
                o_cmd.upper = nn_y[ROW_W-1:0];
                o_cmd.lower = nn_y[ROW_W-1:0];
            end
        end
    end

    assign o_cmd_push = (r_state == F_IDX) && !i_q_full;
    assign o_busy     = (r_state != F_IDLE);

endmodule

// File: design/rrs_back.sv
// back end: line stores, interpolation, min/max tracking and result register
module rrs_back import rrs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_empty,
    input  t_cmd                    i_head,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [OUT_W-1:0] o_cell_value,
    output logic                    o_cell_valid,
    output logic signed [OUT_W-1:0] o_running_min,
    output logic signed [OUT_W-1:0] o_running_max,
    output logic [ROW_W-1:0]        o_upper_source_row,
    output logic [ROW_W-1:0]        o_lower_source_row
);

    typedef enum logic [2:0] {B_IDLE, B_RD1, B_RD2, B_MAC, B_FIN, B_OUT} t_bstate;

    localparam int ACC_W = SAMPLE_W + WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] ONE = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [FRAC_W:0]     HALF = {2'b01, {(FRAC_W-1){1'b0}}};

    t_bstate               r_state;
    logic [2:0]            r_step;
    logic                  r_ovalid;
    logic signed [OUT_W-1:0] r_min;
    logic signed [OUT_W-1:0] r_max;

    t_cmd                  r_cmd;
    logic [SAMPLE_W-1:0]   r_a, r_b, r_c, r_d;
    logic [ACC_W-1:0]      r_top, r_bot, r_hi, r_lo;
    logic signed [OUT_W-1:0] r_val;
    logic                  r_vld;
    logic signed [OUT_W-1:0] r_o_value;
    logic                  r_o_valid;
    logic [ROW_W-1:0]      r_o_upper;
    logic [ROW_W-1:0]      r_o_lower;

    logic [ADDR_W-1:0]     raddr;
    logic [SAMPLE_W-1:0]   rd0;
    logic [SAMPLE_W-1:0]   rd1;
    logic                  we0;
    logic                  we1;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   mul_a;
    logic [WEIGHT_W-1:0]   mul_b;
    logic [WEIGHT_W-1:0]   frac;
    logic [ACC_W-1:0]      prod;
    logic [ACC_W-1:0]      acc_sel;
    logic [ACC_W-1:0]      acc_new;
    logic [FRAC_W+WEIGHT_W-1:0] lo_rnd;
    logic [ACC_W-1:0]      res;
    logic                  all_valid;
    logic signed [OUT_W-1:0] n_min;
    logic signed [OUT_W-1:0] n_max;

    // line stores: slot 0 upper row, slot 1 lower row
    rrs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (i_head.xi),
        .i_wdata (i_head.sample),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    rrs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (i_head.xi),
        .i_wdata (i_head.sample),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign we0      = o_q_pop && i_head.kind == K_LOAD && !i_head.slot;
    assign we1      = o_q_pop && i_head.kind == K_LOAD && i_head.slot;
    assign raddr    = (r_state == B_IDLE) ? i_head.xi : r_cmd.xi + ADDR_W'(1);
    assign out_free = !r_ovalid || i_pop;

    // shared multiply-accumulate: top, bottom, high and low partial sums
    always_comb begin
        unique case (r_step)
            3'd0:    mul_a = {~r_a[SAMPLE_W-1], r_a[SAMPLE_W-2:0]};
            3'd1:    mul_a = {~r_b[SAMPLE_W-1], r_b[SAMPLE_W-2:0]};
            3'd2:    mul_a = {~r_c[SAMPLE_W-1], r_c[SAMPLE_W-2:0]};
            3'd3:    mul_a = {~r_d[SAMPLE_W-1], r_d[SAMPLE_W-2:0]};
            3'd4:    mul_a = r_top[FRAC_W+SAMPLE_W-1:FRAC_W];
            3'd5:    mul_a = r_bot[FRAC_W+SAMPLE_W-1:FRAC_W];
            3'd6:    mul_a = {{(SAMPLE_W-FRAC_W){1'b0}}, r_top[FRAC_W-1:0]};
            default: mul_a = {{(SAMPLE_W-FRAC_W){1'b0}}, r_bot[FRAC_W-1:0]};
        endcase
        frac  = r_step[2] ? r_cmd.fy : r_cmd.fx;
        mul_b = r_step[0] ? frac : ONE - frac;
        prod  = {{WEIGHT_W{1'b0}}, mul_a} * {{SAMPLE_W{1'b0}}, mul_b};
        unique case (r_step[2:1])
            2'd0:    acc_sel = r_top;
            2'd1:    acc_sel = r_bot;
            2'd2:    acc_sel = r_hi;
            default: acc_sel = r_lo;
        endcase
        acc_new = r_step[0] ? acc_sel + prod : prod;
    end

    // rounded bilinear sum, bias removed by flipping the top bit
    assign lo_rnd = r_lo[FRAC_W+WEIGHT_W-1:0] + {{(WEIGHT_W-1){1'b0}}, HALF};
    assign res = r_hi + {{(ACC_W-WEIGHT_W){1'b0}}, lo_rnd[FRAC_W+WEIGHT_W-1:FRAC_W]};
    assign all_valid = (r_a != i_cfg.nodata) && (r_b != i_cfg.nodata)
                    && (r_c != i_cfg.nodata) && (r_d != i_cfg.nodata);

    // tracker update for the request being finished
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (r_cmd.kind == K_FRAME) begin
            n_min = OUT_MAX;
            n_max = OUT_MIN;
        end else if (r_cmd.kind == K_CELL && r_vld) begin
            if (r_val < r_min) begin
                n_min = r_val;
            end
            if (r_val > r_max) begin
                n_max = r_val;
            end
        end
    end

    // control and trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_step   <= 3'd0;
            r_ovalid <= 1'b0;
            r_min    <= OUT_MAX;
            r_max    <= OUT_MIN;
        end else begin
            if (r_state == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
                r_min    <= n_min;
                r_max    <= n_max;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_head.kind == K_CELL) ? B_RD1 : B_OUT;
                    end
                end
                B_RD1: begin
                    r_state <= r_cmd.mode ? B_RD2 : B_FIN;
                end
                B_RD2: begin
                    r_step  <= 3'd0;
                    r_state <= B_MAC;
                end
                B_MAC: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_cmd <= i_head;
                r_val <= '0;
                r_vld <= 1'b0;
            end
            B_RD1: begin
                r_a <= rd0;
                r_c <= rd1;
            end
            B_RD2: begin
                r_b <= rd0;
                r_d <= rd1;
            end
            B_MAC: begin
                unique case (r_step[2:1])
                    2'd0:    r_top <= acc_new;
                    2'd1:    r_bot <= acc_new;
                    2'd2:    r_hi  <= acc_new;
                    default: r_lo  <= acc_new;
                endcase
            end
            B_FIN: begin
                if (r_cmd.mode) begin
                    r_vld <= all_valid;
                    r_val <= all_valid ? {~res[OUT_W-1], res[OUT_W-2:0]} : '0;
                end else begin
                    r_vld <= (r_a != i_cfg.nodata);
                    r_val <= (r_a != i_cfg.nodata) ? {r_a, {FRAC_W{1'b0}}} : '0;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    r_o_value <= r_val;
                    r_o_valid <= r_vld;
                    r_o_upper <= r_cmd.upper;
                    r_o_lower <= r_cmd.lower;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_empty            = !r_ovalid;
    assign o_cell_value       = r_o_value;
    assign o_cell_valid       = r_o_valid;
    assign o_running_min      = r_min;
    assign o_running_max      = r_max;
    assign o_upper_source_row = r_o_upper;
    assign o_lower_source_row = r_o_lower;

endmodule
